// ===== design/fdrs_pkg.sv =====
package fdrs_pkg;

  localparam int DEF_TABLE_DEPTH = 16;
  localparam int DEF_TRACK_BITS  = 13;
  localparam int TAG_W           = 16;
  localparam int STATUS_W        = 2;

  localparam logic [STATUS_W-1:0] ST_SELECTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_SELECT = 1'b1;

  typedef struct packed {
    logic capture;
    logic do_insert;
    logic do_empty;
    logic scan_start;
    logic scan_step;
    logic do_remove;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_select;
    logic empty;
    logic scan_last;
    logic out_free;
  } stat_t;

endpackage

// ===== design/fdrs_ctrl.sv =====
module fdrs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  fdrs_pkg::stat_t stat,
  output fdrs_pkg::cmd_t  cmd
);
  import fdrs_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_REMOVE = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!stat.is_select) begin
          cmd.do_insert = 1'b1;
          state_next    = S_DONE;
        end else if (stat.empty) begin
          cmd.do_empty = 1'b1;
          state_next   = S_DONE;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_REMOVE;
        end
      end
      S_REMOVE: begin
        cmd.do_remove = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/fdrs_dp.sv =====
module fdrs_dp #(
  parameter int TABLE_DEPTH = fdrs_pkg::DEF_TABLE_DEPTH,
  parameter int TRACK_BITS  = fdrs_pkg::DEF_TRACK_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  fdrs_pkg::cmd_t                cmd,
  output fdrs_pkg::stat_t               stat,
  input  logic                          func,
  input  logic                          target_table,
  input  logic [TRACK_BITS-1:0]         req_track,
  input  logic [fdrs_pkg::TAG_W-1:0]    req_tag,
  input  logic [TRACK_BITS-1:0]         head_pos,
  input  logic                          dir_up,
  input  logic                          swap_flag,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fdrs_pkg::STATUS_W-1:0] status,
  output logic [fdrs_pkg::TAG_W-1:0]    out_tag,
  output logic [TRACK_BITS-1:0]         out_track
);
  import fdrs_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int KW = TRACK_BITS + 1;

  logic [TRACK_BITS-1:0] trk [2][TABLE_DEPTH];
  logic [TAG_W-1:0]      tg  [2][TABLE_DEPTH];
  logic [CW-1:0]         cnt [2];

  logic                  sel_func;
  logic                  tsel;
  logic [TRACK_BITS-1:0] i_track;
  logic [TAG_W-1:0]      i_tag;
  logic [TRACK_BITS-1:0] i_head;
  logic                  i_up;

  logic [IW-1:0]         idx;
  logic                  best_valid;
  logic [KW-1:0]         best_key;
  logic [IW-1:0]         best_idx;
  logic [TRACK_BITS-1:0] best_trk;
  logic [TAG_W-1:0]      best_tag;

  logic [STATUS_W-1:0]   res_status;
  logic [TAG_W-1:0]      res_tag;
  logic [TRACK_BITS-1:0] res_track;

  logic [TRACK_BITS-1:0] cur_trk;
  logic [TAG_W-1:0]      cur_tag;
  logic                  ge;
  logic                  same;
  logic [TRACK_BITS-1:0] delta;
  logic [KW-1:0]         cur_key;
  logic                  better;
  logic                  full;

  // nearest in sweep direction first: key = {other side, distance}
  always_comb begin
    cur_trk = trk[tsel][idx];
    cur_tag = tg[tsel][idx];
    ge      = (cur_trk >= i_head);
    same    = i_up ? ge : (cur_trk <= i_head);
    delta   = ge ? (cur_trk - i_head) : (i_head - cur_trk);
    cur_key = {~same, delta};
    better  = !best_valid || (cur_key < best_key);
    full    = (cnt[tsel] == CW'(TABLE_DEPTH));
  end

  assign stat.is_select = (sel_func == FUNC_SELECT);
  assign stat.empty     = (cnt[tsel] == '0);
  assign stat.scan_last = ((CW'(idx) + CW'(1)) == cnt[tsel]);
  assign stat.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sel_func <= func;
      tsel     <= (func == FUNC_SELECT) ? swap_flag : target_table;
      i_track  <= req_track;
      i_tag    <= req_tag;
      i_head   <= head_pos;
      i_up     <= dir_up;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_insert && !full) begin
      trk[tsel][cnt[tsel][IW-1:0]] <= i_track;
      tg[tsel][cnt[tsel][IW-1:0]]  <= i_tag;
    end
    if (cmd.do_remove) begin
      for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
        if (IW'(i) >= best_idx) begin
          trk[tsel][i] <= trk[tsel][i+1];
          tg[tsel][i]  <= tg[tsel][i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt[0] <= '0;
      cnt[1] <= '0;
    end else if (cmd.do_insert && !full) begin
      cnt[tsel] <= cnt[tsel] + CW'(1);
    end else if (cmd.do_remove) begin
      cnt[tsel] <= cnt[tsel] - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid <= 1'b0;
    end else if (cmd.scan_start) begin
      best_valid <= 1'b0;
    end else if (cmd.scan_step && better) begin
      best_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      idx <= '0;
    end else if (cmd.scan_step) begin
      idx <= idx + IW'(1);
      if (better) begin
        best_key <= cur_key;
        best_idx <= idx;
        best_trk <= cur_trk;
        best_tag <= cur_tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_insert) begin
      res_status <= full ? ST_FULL : ST_INSERTED;
      res_tag    <= '0;
      res_track  <= '0;
    end else if (cmd.do_empty) begin
      res_status <= ST_EMPTY;
      res_tag    <= '0;
      res_track  <= '0;
    end else if (cmd.do_remove) begin
      res_status <= ST_SELECTED;
      res_tag    <= best_tag;
      res_track  <= best_trk;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status    <= res_status;
      out_tag   <= res_tag;
      out_track <= res_track;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (cnt[0] <= CW'(TABLE_DEPTH)) && (cnt[1] <= CW'(TABLE_DEPTH)))
    else $error("table count above depth");

  a_pick_found: assert property (@(posedge clk) disable iff (rst)
    cmd.do_remove |-> best_valid)
    else $error("remove without a picked entry");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("output item overwritten while stalled");

  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    cmd.do_remove |=> (cnt[tsel] == ($past(cnt[tsel]) - CW'(1))))
    else $error("count not decremented on remove");

endmodule

// ===== design/flook_disk_request_scheduler.sv =====
// FLOOK disk request scheduler, two request tables of TABLE_DEPTH entries each.
// Input channel (in_valid / in_stall): func 0 appends (req_track, req_tag) to
// the table named by target_table; func 1 serves the table named by swap_flag,
// picking the nearest request on the dir_up side of head_pos, else the nearest
// on the other side, oldest first on ties; the pick is removed and returned.
// Output channel (out_valid / out_stall): one item per input item carrying
// status (selected, inserted, empty, full), out_tag and out_track.
// Timing: an insert, or a select on an empty table, goes from capture through
// decode to the done state, which loads the output register. A select on a
// non-empty table adds a scan state, where the single distance compare visits
// one entry per cycle, then a remove state, before the done state.
// The result sits in an output register; a new item is accepted while it
// waits, and a stalled result holds until taken while the next one waits
// finished inside the block with in_stall high.
// Reset empties both tables and drops any pending output item.
module flook_disk_request_scheduler #(
  parameter int TABLE_DEPTH = fdrs_pkg::DEF_TABLE_DEPTH,
  parameter int TRACK_BITS  = fdrs_pkg::DEF_TRACK_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          func,
  input  logic                          target_table,
  input  logic [TRACK_BITS-1:0]         req_track,
  input  logic [fdrs_pkg::TAG_W-1:0]    req_tag,
  input  logic [TRACK_BITS-1:0]         head_pos,
  input  logic                          dir_up,
  input  logic                          swap_flag,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fdrs_pkg::STATUS_W-1:0] status,
  output logic [fdrs_pkg::TAG_W-1:0]    out_tag,
  output logic [TRACK_BITS-1:0]         out_track
);
  import fdrs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  fdrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  fdrs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TRACK_BITS  (TRACK_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .func         (func),
    .target_table (target_table),
    .req_track    (req_track),
    .req_tag      (req_tag),
    .head_pos     (head_pos),
    .dir_up       (dir_up),
    .swap_flag    (swap_flag),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .out_tag      (out_tag),
    .out_track    (out_track)
  );

endmodule
